### sv/rpai_pkg.sv
// rpai_pkg: shared constants, cordic angle table and stage structs
// for the ray / annulus-sector hit test; no dependencies
package rpai_pkg;

	localparam int DIV_BITS     = 64;  // dividend width, one quotient bit per cell
	localparam int CORDIC_STEPS = 23;
	localparam int CW           = 59;  // cordic vector width, |x|,|z| < 2^31 scaled by 2^24
	localparam int LATENCY      = 93;  // accept edge to the edge that samples done

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_PLANE_HEIGHT = 3'd0,
		REG_INNER_SQ     = 3'd1,
		REG_OUTER_SQ     = 3'd2,
		REG_AZ_LOW       = 3'd3,
		REG_AZ_HIGH      = 3'd4,
		REG_FACES_UP     = 3'd5,
		REG_CASTS        = 3'd6,
		REG_MIN_DIST     = 3'd7
	} reg_idx_t;

	// arctangent of 2^-i in units of 2^-24 turn
	localparam logic [23:0] ATAN_TURN24 [CORDIC_STEPS] = '{
		24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
		24'd41718,   24'd20860,   24'd10430,  24'd5215,   24'd2608,   24'd1304,
		24'd652,     24'd326,     24'd163,    24'd81,     24'd41,     24'd20,
		24'd10,      24'd5,       24'd3,      24'd1,      24'd1
	};

	// sideband that rides along with the divider
	typedef struct packed {
		logic               mode;
		logic               miss;
		logic               sgn_t;
		logic               sgn_x;
		logic               sgn_z;
		logic signed [31:0] ox;
		logic signed [31:0] oz;
	} div_side_t;

	// lane 0: t, lane 1: x offset, lane 2: z offset
	typedef struct packed {
		logic [31:0]                dvs;
		logic [2:0][31:0]           rem;
		logic [2:0][DIV_BITS-1:0]   quo;
		div_side_t                  side;
	} div_lane_t;

	typedef struct packed {
		logic               ok;
		logic               mode;
		logic [30:0]        hit_dist;
		logic signed [31:0] px;
		logic signed [31:0] pz;
	} cor_side_t;

	typedef struct packed {
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic [23:0]          acc;
		cor_side_t            side;
	} cor_t;

endpackage

### sv/ray_part_annulus_intersect_unit.sv
// ray_part_annulus_intersect_unit: top level of the ray / annulus-sector hit test
// depends on rpai_pkg, rpai_div_cell, rpai_cordic_cell
//
// usage
//  - a ray transfers on a rising edge with start high; busy is always low,
//    so a new ray may be offered every cycle
//  - each ray gives exactly one result, shown for one cycle with done high;
//    the receiver cannot stall, results leave in acceptance order
//  - the path is registered through 2 entry stages, 64 divider cells,
//    3 stages for clamp, squares and radius test, 23 cordic cells and
//    1 output register
//  - throughput is one ray per cycle: every cell hands its data on each cycle
//  - the user writes registers through cfg_we / cfg_index / cfg_data only
//    while no ray is in flight, which the block does not enforce; the stages that use them read them directly
//  - reset clears the register file to defaults and drops every ray in flight
module ray_part_annulus_intersect_unit (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// ray in
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	// result out
	output logic               done,
	output logic               is_hit,
	output logic [30:0]        hit_distance,
	output logic               normal_down,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z
);

	localparam logic signed [42:0] LIM31 = 43'sd2147483648;
	localparam logic [63:0]        CLAMP40 = 64'h0000_0100_0000_0000;

	logic signed [31:0] plane_height_q;
	logic [30:0]        inner_sq_q;
	logic [30:0]        outer_sq_q;
	logic [16:0]        az_low_q;
	logic [16:0]        az_high_q;
	logic               faces_up_q;
	logic               casts_q;
	logic [15:0]        min_dist_q;

	// config register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_height_q <= '0;
			inner_sq_q     <= 31'd41943;
			outer_sq_q     <= 31'd65536;
			az_low_q       <= '0;
			az_high_q      <= 17'd65536;
			faces_up_q     <= 1'b1;
			casts_q        <= 1'b1;
			min_dist_q     <= 16'd7;
		end else if (cfg_we) begin
			case (rpai_pkg::reg_idx_t'(cfg_index))
				rpai_pkg::REG_PLANE_HEIGHT: plane_height_q <= cfg_data;
				rpai_pkg::REG_INNER_SQ:     inner_sq_q     <= cfg_data[30:0];
				rpai_pkg::REG_OUTER_SQ:     outer_sq_q     <= cfg_data[30:0];
				rpai_pkg::REG_AZ_LOW:       az_low_q       <= cfg_data[16:0];
				rpai_pkg::REG_AZ_HIGH:      az_high_q      <= cfg_data[16:0];
				rpai_pkg::REG_FACES_UP:     faces_up_q     <= cfg_data[0];
				rpai_pkg::REG_CASTS:        casts_q        <= cfg_data[0];
				rpai_pkg::REG_MIN_DIST:     min_dist_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		logic [32:0] s;
		s = {v[31], v};
		return v[31] ? 32'(-s) : v;
	endfunction

	// stage 1: distance to plane and magnitudes
	logic        vld_s1, mode_s1, miss_s1;
	logic        sn_s1, sdx_s1, sdy_s1, sdz_s1;
	logic [31:0] nm_s1, dxm_s1, dym_s1, dzm_s1;
	logic signed [31:0] ox_s1, oz_s1;
	logic [32:0] num;

	assign num = {plane_height_q[31], plane_height_q} - {origin_y[31], origin_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		miss_s1 <= (mode && !casts_q) || (dir_y == '0);
		sn_s1   <= num[32];
		nm_s1   <= num[32] ? 32'(-num) : num[31:0];
		sdx_s1  <= dir_x[31];
		sdy_s1  <= dir_y[31];
		sdz_s1  <= dir_z[31];
		dxm_s1  <= mag32(dir_x);
		dym_s1  <= mag32(dir_y);
		dzm_s1  <= mag32(dir_z);
		ox_s1   <= origin_x;
		oz_s1   <= origin_z;
	end

	// stage 2: dividends, one multiplier per offset lane
	rpai_pkg::div_lane_t d [0:rpai_pkg::DIV_BITS];
	logic                dv [0:rpai_pkg::DIV_BITS];
	rpai_pkg::div_lane_t d_s2;
	logic                vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		d_s2.dvs        <= dym_s1;
		d_s2.rem        <= '0;
		d_s2.quo[0]     <= {16'b0, nm_s1, 16'b0};
		d_s2.quo[1]     <= nm_s1 * dxm_s1;
		d_s2.quo[2]     <= nm_s1 * dzm_s1;
		d_s2.side.mode  <= mode_s1;
		d_s2.side.miss  <= miss_s1;
		d_s2.side.sgn_t <= sn_s1 ^ sdy_s1;
		d_s2.side.sgn_x <= sn_s1 ^ sdy_s1 ^ sdx_s1;
		d_s2.side.sgn_z <= sn_s1 ^ sdy_s1 ^ sdz_s1;
		d_s2.side.ox    <= ox_s1;
		d_s2.side.oz    <= oz_s1;
	end

	assign d[0]  = d_s2;
	assign dv[0] = vld_s2;

	// divider chain, one quotient bit per cell
	for (genvar k = 0; k < rpai_pkg::DIV_BITS; k++) begin : g_div
		rpai_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (dv[k]),
			.d_in    (d[k]),
			.vld_out (dv[k+1]),
			.d_out   (d[k+1])
		);
	end

	// stage 3: distance test, clamp and hit point
	rpai_pkg::div_lane_t dq;
	logic [63:0]         qt, qx, qz;
	logic                t_small;
	logic [40:0]         cxm, czm;
	logic signed [42:0]  cx, cz, px43, pz43;

	assign dq = d[rpai_pkg::DIV_BITS];
	assign qt = dq.quo[0];
	assign qx = dq.quo[1];
	assign qz = dq.quo[2];
	assign t_small = (dq.side.sgn_t && (qt != '0)) || (qt <= {48'b0, min_dist_q});
	assign cxm  = (qx > CLAMP40) ? CLAMP40[40:0] : qx[40:0];
	assign czm  = (qz > CLAMP40) ? CLAMP40[40:0] : qz[40:0];
	assign cx   = dq.side.sgn_x ? -$signed({2'b0, cxm}) : $signed({2'b0, cxm});
	assign cz   = dq.side.sgn_z ? -$signed({2'b0, czm}) : $signed({2'b0, czm});
	assign px43 = {{11{dq.side.ox[31]}}, dq.side.ox} + cx;
	assign pz43 = {{11{dq.side.oz[31]}}, dq.side.oz} + cz;

	logic               vld_s3;
	rpai_pkg::cor_side_t sd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= dv[rpai_pkg::DIV_BITS];
		end
	end

	always_ff @(posedge clk) begin
		sd_s3.ok       <= !dq.side.miss && !t_small &&
			(px43 > -LIM31) && (px43 < LIM31) && (pz43 > -LIM31) && (pz43 < LIM31);
		sd_s3.mode     <= dq.side.mode;
		sd_s3.hit_dist <= (qt > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : qt[30:0];
		sd_s3.px       <= px43[31:0];
		sd_s3.pz       <= pz43[31:0];
	end

	// stage 4: squares of the hit point
	logic               vld_s4;
	rpai_pkg::cor_side_t sd_s4;
	logic [63:0]        sqx_s4, sqz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		sd_s4  <= sd_s3;
		sqx_s4 <= mag32(sd_s3.px) * mag32(sd_s3.px);
		sqz_s4 <= mag32(sd_s3.pz) * mag32(sd_s3.pz);
	end

	// stage 5: radius window and cordic start vector
	logic [63:0]                  rsum;
	logic                         rad_ok;
	logic signed [rpai_pkg::CW-1:0] a0, b0;

	assign rsum   = sqx_s4 + sqz_s4;
	assign rad_ok = ({17'b0, inner_sq_q, 16'b0} < rsum) && (rsum < {17'b0, outer_sq_q, 16'b0});
	assign a0 = {{(rpai_pkg::CW-56){sd_s4.px[31]}}, sd_s4.px, 24'b0};
	assign b0 = {{(rpai_pkg::CW-56){sd_s4.pz[31]}}, sd_s4.pz, 24'b0};

	rpai_pkg::cor_t c [0:rpai_pkg::CORDIC_STEPS];
	logic           cv [0:rpai_pkg::CORDIC_STEPS];
	rpai_pkg::cor_t c_s5;
	logic           vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	// a point behind the z axis is turned by half a turn first
	always_ff @(posedge clk) begin
		c_s5.side.ok       <= sd_s4.ok && rad_ok;
		c_s5.side.mode     <= sd_s4.mode;
		c_s5.side.hit_dist <= sd_s4.hit_dist;
		c_s5.side.px       <= sd_s4.px;
		c_s5.side.pz       <= sd_s4.pz;
		c_s5.a             <= sd_s4.pz[31] ? -a0 : a0;
		c_s5.b             <= sd_s4.pz[31] ? -b0 : b0;
		c_s5.acc           <= sd_s4.pz[31] ? 24'h80_0000 : 24'h00_0000;
	end

	assign c[0]  = c_s5;
	assign cv[0] = vld_s5;

	// cordic chain, one rotation per cell
	for (genvar k = 0; k < rpai_pkg::CORDIC_STEPS; k++) begin : g_cor
		rpai_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (cv[k]),
			.c_in    (c[k]),
			.shift   (5'(k)),
			.angle   (rpai_pkg::ATAN_TURN24[k]),
			.vld_out (cv[k+1]),
			.c_out   (c[k+1])
		);
	end

	// output register: sector test and result fields
	rpai_pkg::cor_t cl;
	logic [16:0]    az;
	logic           hit;

	assign cl  = c[rpai_pkg::CORDIC_STEPS];
	assign az  = {1'b0, cl.acc[23:8]};
	assign hit = cl.side.ok && (az >= az_low_q) && (az <= az_high_q);

	logic               done_q, is_hit_q, normal_down_q;
	logic [30:0]        dist_q;
	logic signed [31:0] px_q, py_q, pz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cv[rpai_pkg::CORDIC_STEPS];
		end
	end

	// shadow hits report only the distance
	always_ff @(posedge clk) begin
		is_hit_q      <= hit;
		dist_q        <= hit ? cl.side.hit_dist : '0;
		normal_down_q <= hit && !cl.side.mode && !faces_up_q;
		px_q          <= (hit && !cl.side.mode) ? cl.side.px : '0;
		py_q          <= (hit && !cl.side.mode) ? plane_height_q : '0;
		pz_q          <= (hit && !cl.side.mode) ? cl.side.pz : '0;
	end

	assign done         = done_q;
	assign is_hit       = is_hit_q;
	assign hit_distance = dist_q;
	assign normal_down  = normal_down_q;
	assign point_x      = px_q;
	assign point_y      = py_q;
	assign point_z      = pz_q;

endmodule

### sv/rpai_div_cell.sv
// rpai_div_cell: one restoring division step for three lanes sharing a divisor
// depends on rpai_pkg
module rpai_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_in,
	input  rpai_pkg::div_lane_t d_in,
	output logic               vld_out,
	output rpai_pkg::div_lane_t d_out
);

	rpai_pkg::div_lane_t nxt;
	rpai_pkg::div_lane_t lane_q;
	logic                vld_q;

	always_comb begin
		logic [32:0] rp;
		logic [32:0] diff;
		logic        ge;
		nxt = d_in;
		for (int j = 0; j < 3; j++) begin
			rp   = {d_in.rem[j], d_in.quo[j][rpai_pkg::DIV_BITS-1]};
			diff = rp - {1'b0, d_in.dvs};
			ge   = (rp >= {1'b0, d_in.dvs});
			nxt.rem[j] = ge ? diff[31:0] : rp[31:0];
			nxt.quo[j] = {d_in.quo[j][rpai_pkg::DIV_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		lane_q <= nxt;
	end

	assign vld_out = vld_q;
	assign d_out   = lane_q;

endmodule

### sv/rpai_cordic_cell.sv
// rpai_cordic_cell: one vectoring rotation step with angle accumulation
// depends on rpai_pkg
module rpai_cordic_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld_in,
	input  rpai_pkg::cor_t c_in,
	input  logic [4:0]     shift,
	input  logic [23:0]    angle,
	output logic           vld_out,
	output rpai_pkg::cor_t c_out
);

	rpai_pkg::cor_t nxt;
	rpai_pkg::cor_t cor_q;
	logic           vld_q;

	always_comb begin
		logic signed [rpai_pkg::CW-1:0] a_sh;
		logic signed [rpai_pkg::CW-1:0] b_sh;
		a_sh = $signed(c_in.a) >>> shift;
		b_sh = $signed(c_in.b) >>> shift;
		nxt  = c_in;
		if ($signed(c_in.a) > 0) begin
			nxt.b   = $signed(c_in.b) + a_sh;
			nxt.a   = $signed(c_in.a) - b_sh;
			nxt.acc = c_in.acc + angle;
		end else begin
			nxt.b   = $signed(c_in.b) - a_sh;
			nxt.a   = $signed(c_in.a) + b_sh;
			nxt.acc = c_in.acc - angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		cor_q <= nxt;
	end

	assign vld_out = vld_q;
	assign c_out   = cor_q;

endmodule

### sv/rpai_checker.sv
// rpai_checker: port-level checks of the hit test unit, bound to the top level
// depends on rpai_pkg and ray_part_annulus_intersect_unit
module rpai_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               is_hit,
	input logic [30:0]        hit_distance,
	input logic               normal_down,
	input logic signed [31:0] point_x,
	input logic signed [31:0] point_y,
	input logic signed [31:0] point_z
);

	// every accepted ray returns after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(rpai_pkg::LATENCY) done)
		else $error("accepted ray produced no result");

	// no result without a ray accepted the fixed latency before
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, rpai_pkg::LATENCY))
		else $error("result without matching transfer");

	// a miss carries all-zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !is_hit |-> hit_distance == '0 && !normal_down &&
			point_x == '0 && point_y == '0 && point_z == '0)
		else $error("miss with nonzero fields");

	// a hit lies beyond the minimum distance, so never at zero
	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_hit |-> hit_distance != '0)
		else $error("hit at zero distance");

endmodule

bind ray_part_annulus_intersect_unit rpai_checker u_rpai_checker (.*);
